@@ rtl/nfst_pkg.sv @@
// Shared constants, codes and types of the next-fit slot table.
`default_nettype none
package nfst_pkg;

  localparam int DEPTH      = 1024;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = IDX_W + 1;
  localparam int ROW_BITS   = 32;
  localparam int ROW_W      = $clog2(ROW_BITS);
  localparam int ROWS       = DEPTH / ROW_BITS;
  localparam int RSEL_W     = IDX_W - ROW_W;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_SLOT_LIMIT = '0;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

  typedef enum logic [1:0] {
    OP_FIND   = 2'd0,
    OP_ATTACH = 2'd1,
    OP_DETACH = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN
  } fsm_t;

  // single-bit update of the occupancy map
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic             val;
  } occ_wr_t;

endpackage
`default_nettype wire

@@ rtl/nfst_entry_ram.sv @@
// Entry store: one write port, one read port with registered read data.
`default_nettype none
module nfst_entry_ram
  import nfst_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [IDX_W-1:0]      waddr,
  input  wire logic [DATA_WIDTH-1:0] wdata,
  input  wire logic                  re,
  input  wire logic [IDX_W-1:0]      raddr,
  output logic      [DATA_WIDTH-1:0] rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/nfst_occ_map.sv @@
// Occupancy map: one bit per slot in rows, row lookup and first-free encoder.
`default_nettype none
module nfst_occ_map
  import nfst_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire occ_wr_t             wr,
  input  wire logic [RSEL_W-1:0]   rd_row,
  input  wire logic [ROW_BITS-1:0] mask,
  output logic      [ROW_BITS-1:0] row_bits,
  output logic                     hit,
  output logic      [ROW_W-1:0]    pos
);

  logic [ROW_BITS-1:0] occ [ROWS];
  logic [ROW_BITS-1:0] free;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < ROWS; r++) begin
        occ[r] <= '0;
      end
    end else if (wr.en) begin
      occ[wr.idx[IDX_W-1:ROW_W]][wr.idx[ROW_W-1:0]] <= wr.val;
    end
  end

  assign row_bits = occ[rd_row];
  assign free     = ~row_bits & mask;
  assign hit      = |free;

  // lowest free bit wins
  always_comb begin
    pos = '0;
    for (int i = ROW_BITS - 1; i >= 0; i--) begin
      if (free[i]) begin
        pos = ROW_W'(i);
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/next_fit_slot_table.sv @@
// Next-fit slot table: handle allocator with rotating search pointer.
//
// Input channel (in_valid/in_stall) carries opcode, slot_index, data_value;
// a transfer happens when in_valid is high and in_stall low. Output channel
// (out_valid/out_stall) returns status, slot_found, data_out, used_count,
// one result per input transfer, in order.
// One operation is in flight at a time. Attach, detach and no-op read the
// entry store in the transfer cycle; S_EXEC then commits and loads the
// result register once the output register is free.
// Find-free walks the occupancy map one 32-slot row per cycle from the next
// pointer until a free slot turns up or the whole range has been searched.
// A stalled result sits in the output register; one more item may be taken,
// but it waits before its commit until that register frees up.
// Reset clears the occupancy map (all slots empty), the count and the next
// pointer, and sets slot_limit to 1024. No clearing pass is needed: an
// entry whose occupancy bit is low reads as zero.
// slot_limit is written over the APB port at byte address 0; the user must
// write it only while the block is idle, as the block does not enforce it.
`default_nettype none
module next_fit_slot_table
  import nfst_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // APB configuration
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [PADDR_W-1:0]    paddr,
  input  wire logic [PDATA_W-1:0]    pwdata,
  output logic      [PDATA_W-1:0]    prdata,
  output logic                       pready,
  // input channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            opcode,
  input  wire logic [IDX_W-1:0]      slot_index,
  input  wire logic [DATA_WIDTH-1:0] data_value,
  // output channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic      [1:0]            status,
  output logic      [IDX_W-1:0]      slot_found,
  output logic      [DATA_WIDTH-1:0] data_out,
  output logic      [CNT_W-1:0]      used_count
);

  fsm_t                  state, state_next;
  logic [CNT_W-1:0]      slot_limit;
  logic [CNT_W-1:0]      size_act, sz_m1;
  logic [RSEL_W-1:0]     last_row;

  op_t                   op_q;
  logic [IDX_W-1:0]      idx_q;
  logic [DATA_WIDTH-1:0] data_q;

  logic [CNT_W-1:0]      next_ptr, next_ptr_next;
  logic [CNT_W-1:0]      used_cnt, used_cnt_next;
  logic [IDX_W-1:0]      start_ptr, start_sel;
  logic [RSEL_W-1:0]     row_q, row_q_next;
  logic                  wrapped, wrapped_next;

  logic                  in_acc, out_free, cfg_wr, in_range;
  logic                  out_load;
  logic [1:0]            status_next;
  logic [IDX_W-1:0]      found_next;
  logic [DATA_WIDTH-1:0] dout_next;

  logic [RSEL_W-1:0]     rd_row;
  logic [ROW_BITS-1:0]   scan_mask, size_mask, low_mask, pos_mask;
  logic [ROW_BITS-1:0]   row_bits;
  logic                  hit, first_row, final_row, occupied;
  logic [ROW_W-1:0]      pos;
  logic [IDX_W-1:0]      found_slot;

  occ_wr_t               occ_wr;
  logic                  ram_we;
  logic [DATA_WIDTH-1:0] ram_rdata;

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[PADDR_W-1:2] == REG_SLOT_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_limit <= CNT_W'(DEPTH);
    end else if (cfg_wr) begin
      slot_limit <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata = (paddr[PADDR_W-1:2] == REG_SLOT_LIMIT) ?
                  PDATA_W'(slot_limit) : '0;

  // zero acts as one, anything past DEPTH as DEPTH
  always_comb begin
    size_act = slot_limit;
    if (slot_limit == '0) begin
      size_act = CNT_W'(1);
    end else if (slot_limit > CNT_W'(DEPTH)) begin
      size_act = CNT_W'(DEPTH);
    end
  end

  assign sz_m1    = size_act - CNT_W'(1);
  assign last_row = sz_m1[IDX_W-1:ROW_W];

  // ---------------- handshake ----------------
  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign start_sel = (next_ptr >= size_act) ? '0 : next_ptr[IDX_W-1:0];
  assign in_range  = ({1'b0, idx_q} < size_act);

  // ---------------- occupancy scan ----------------
  assign rd_row    = (state == S_SCAN) ? row_q : idx_q[IDX_W-1:ROW_W];
  assign first_row = (row_q == start_ptr[IDX_W-1:ROW_W]) && !wrapped;
  assign final_row = (row_q == start_ptr[IDX_W-1:ROW_W]) && wrapped;
  assign low_mask  = (ROW_BITS'(1) << start_ptr[ROW_W-1:0]) - ROW_BITS'(1);
  assign size_mask = (row_q == last_row) ?
                     ({ROW_BITS{1'b1}} >> (ROW_W'(ROW_BITS - 1) - sz_m1[ROW_W-1:0])) :
                     {ROW_BITS{1'b1}};

  always_comb begin
    pos_mask = {ROW_BITS{1'b1}};
    if (first_row) begin
      pos_mask = ~low_mask;
    end else if (final_row) begin
      pos_mask = low_mask;
    end
  end

  assign scan_mask  = size_mask & pos_mask;
  assign found_slot = {row_q, pos};
  assign occupied   = row_bits[idx_q[ROW_W-1:0]];

  nfst_occ_map u_occ (
    .clk      (clk),
    .rst      (rst),
    .wr       (occ_wr),
    .rd_row   (rd_row),
    .mask     (scan_mask),
    .row_bits (row_bits),
    .hit      (hit),
    .pos      (pos)
  );

  // Reads are issued only at the input transfer and writes only at commit,
  // so a read and a write to the store never meet in the same cycle.
  nfst_entry_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_q),
    .wdata (data_q),
    .re    (in_acc),
    .raddr (slot_index),
    .rdata (ram_rdata)
  );

  // ---------------- control ----------------
  always_comb begin
    state_next    = state;
    out_load      = 1'b0;
    status_next   = STAT_OK;
    found_next    = idx_q;
    dout_next     = '0;
    used_cnt_next = used_cnt;
    next_ptr_next = next_ptr;
    row_q_next    = row_q;
    wrapped_next  = wrapped;
    occ_wr        = '{en: 1'b0, idx: idx_q, val: 1'b0};
    ram_we        = 1'b0;

    case (state)
      S_IDLE: begin
        if (in_acc) begin
          state_next = (op_t'(opcode) == OP_FIND) ? S_SCAN : S_EXEC;
        end
      end

      S_EXEC: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
          case (op_q)
            OP_ATTACH: begin
              if (!in_range) begin
                status_next = STAT_RANGE;
              end else begin
                ram_we = 1'b1;
                occ_wr = '{en: 1'b1, idx: idx_q, val: (data_q != '0)};
                if (used_cnt < CNT_W'(DEPTH)) begin
                  used_cnt_next = used_cnt + CNT_W'(1);
                end
              end
            end
            OP_DETACH: begin
              if (!in_range) begin
                status_next = STAT_RANGE;
              end else begin
                dout_next     = occupied ? ram_rdata : '0;
                occ_wr        = '{en: 1'b1, idx: idx_q, val: 1'b0};
                next_ptr_next = {1'b0, idx_q};
                if (used_cnt != '0) begin
                  used_cnt_next = used_cnt - CNT_W'(1);
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        if (hit) begin
          if (out_free) begin
            out_load      = 1'b1;
            found_next    = found_slot;
            next_ptr_next = {1'b0, found_slot} + CNT_W'(1);
            state_next    = S_IDLE;
          end
        end else if (final_row) begin
          if (out_free) begin
            out_load    = 1'b1;
            status_next = STAT_FULL;
            state_next  = S_IDLE;
          end
        end else begin
          // wrap to row 0 past the last row in use
          if (row_q == last_row) begin
            row_q_next   = '0;
            wrapped_next = 1'b1;
          end else begin
            row_q_next = row_q + RSEL_W'(1);
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      used_cnt  <= '0;
      next_ptr  <= '0;
    end else begin
      state    <= state_next;
      used_cnt <= used_cnt_next;
      next_ptr <= next_ptr_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_q      <= op_t'(opcode);
      idx_q     <= slot_index;
      data_q    <= data_value;
      start_ptr <= start_sel;
      row_q     <= start_sel[IDX_W-1:ROW_W];
      wrapped   <= 1'b0;
    end else begin
      row_q   <= row_q_next;
      wrapped <= wrapped_next;
    end
    if (out_load) begin
      status     <= status_next;
      slot_found <= found_next;
      data_out   <= dout_next;
      used_count <= used_cnt_next;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    used_cnt <= CNT_W'(DEPTH))
    else $error("in-use count above table depth");

  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    next_ptr <= CNT_W'(DEPTH))
    else $error("next pointer past table depth");

  a_scan_row: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (row_q <= last_row))
    else $error("scan row beyond configured size");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (state != S_IDLE))
    else $error("input transfer not followed by work");
`endif

endmodule
`default_nettype wire
